// ===== rtl/igsf_pkg.sv =====
// ----------------------------------------------------------------------------
// igsf_pkg
// Shared types and constants of the IMU gravity split filter.
// ----------------------------------------------------------------------------
package igsf_pkg;

  localparam int FILTER_FRACTION_BITS = 16;
  localparam int GRAV_W               = FILTER_FRACTION_BITS + 14;
  localparam int ACCEL_SAT            = 6144;
  localparam int ROUND_HALF           = 32768;
  localparam int QUEUE_DEPTH          = 2;
  localparam int QPTR_W               = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W               = $clog2(QUEUE_DEPTH + 1);
  localparam int PADDR_W              = 4;

  typedef enum logic [1:0] {
    REG_SMOOTHING = 2'd0,
    REG_LIMIT     = 2'd1,
    REG_GAIN      = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [15:0] smoothing_factor;
    logic [14:0] accel_limit;
    logic [15:0] rate_gain;
  } cfg_t;

  typedef struct packed {
    logic [2:0][13:0] accel;
    logic [2:0][15:0] omega;
  } frame_t;

endpackage

// ===== rtl/igsf_front.sv =====
// ----------------------------------------------------------------------------
// igsf_front
// Accepts sensor frames, applies read-fail hold, limit check, saturation and
// rate scaling, and pushes the classified frame into the queue.
// ----------------------------------------------------------------------------
module igsf_front (
  input  logic               clk,
  input  logic               rst,
  input  igsf_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               read_ok,
  input  logic signed [15:0] accel_x_sample,
  input  logic signed [15:0] accel_y_sample,
  input  logic signed [15:0] accel_z_sample,
  input  logic signed [15:0] rate_x_raw,
  input  logic signed [15:0] rate_y_raw,
  input  logic signed [15:0] rate_z_raw,
  input  logic               queue_full,
  output logic               push,
  output igsf_pkg::frame_t   frame
);
  import igsf_pkg::*;

  logic signed [15:0] accel_raw  [3];
  logic signed [15:0] rate_raw   [3];
  logic signed [13:0] held_accel [3];
  logic signed [15:0] held_omega [3];
  logic signed [13:0] accel_sel  [3];
  logic signed [15:0] omega_sel  [3];
  logic signed [16:0] accel_ext  [3];
  logic signed [32:0] rate_prod  [3];
  logic signed [16:0] limit_ext;

  assign accel_raw[0] = accel_x_sample;
  assign accel_raw[1] = accel_y_sample;
  assign accel_raw[2] = accel_z_sample;
  assign rate_raw[0]  = rate_x_raw;
  assign rate_raw[1]  = rate_y_raw;
  assign rate_raw[2]  = rate_z_raw;

  assign in_ready  = !queue_full;
  assign push      = in_valid && in_ready;
  assign limit_ext = $signed({2'b00, cfg.accel_limit});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      accel_ext[i] = {accel_raw[i][15], accel_raw[i]};
      accel_sel[i] = held_accel[i];
      if (read_ok && (accel_ext[i] <= limit_ext) && (accel_ext[i] >= -limit_ext)) begin
        if (accel_ext[i] > 17'(ACCEL_SAT)) begin
          accel_sel[i] = 14'(ACCEL_SAT);
        end else if (accel_ext[i] < -17'(ACCEL_SAT)) begin
          accel_sel[i] = -14'(ACCEL_SAT);
        end else begin
          accel_sel[i] = accel_ext[i][13:0];
        end
      end
      rate_prod[i] = rate_raw[i] * $signed({1'b0, cfg.rate_gain}) + 33'sd32768;
      omega_sel[i] = read_ok ? rate_prod[i][31:16] : held_omega[i];
      frame.accel[i] = accel_sel[i];
      frame.omega[i] = omega_sel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        held_accel[i] <= '0;
        held_omega[i] <= '0;
      end
    end else if (push) begin
      for (int i = 0; i < 3; i++) begin
        held_accel[i] <= accel_sel[i];
        held_omega[i] <= omega_sel[i];
      end
    end
  end

endmodule

// ===== rtl/igsf_queue.sv =====
// ----------------------------------------------------------------------------
// igsf_queue
// Short frame queue between the classifier and the filter stage.
// ----------------------------------------------------------------------------
module igsf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  igsf_pkg::frame_t frame_in,
  input  logic             pop,
  output igsf_pkg::frame_t frame_out,
  output logic             full,
  output logic             empty
);
  import igsf_pkg::*;

  frame_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign frame_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= frame_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count over depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1)) else $error("count did not advance");

endmodule

// ===== rtl/igsf_back.sv =====
// ----------------------------------------------------------------------------
// igsf_back
// Per-axis gravity low-pass filter and output register.
// ----------------------------------------------------------------------------
module igsf_back (
  input  logic               clk,
  input  logic               rst,
  input  igsf_pkg::cfg_t     cfg,
  input  igsf_pkg::frame_t   head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] body  [3],
  output logic signed [13:0] total [3],
  output logic signed [15:0] omega [3]
);
  import igsf_pkg::*;

  localparam int SUM_W = GRAV_W + 18;

  logic signed [GRAV_W-1:0] gravity      [3];
  logic signed [GRAV_W-1:0] gravity_next [3];
  logic signed [SUM_W-1:0]  prod_g       [3];
  logic signed [31:0]       prod_a       [3];
  logic signed [SUM_W-1:0]  sum          [3];
  logic signed [GRAV_W:0]   grav_rnd     [3];
  logic signed [15:0]       body_w       [3];
  logic signed [13:0]       head_accel   [3];
  logic signed [17:0]       alpha;
  logic signed [17:0]       beta;
  logic                     take;

  assign alpha = $signed({2'b00, cfg.smoothing_factor});
  assign beta  = 18'sd65536 - alpha;
  assign take  = head_valid && (!out_valid || out_ready);
  assign pop   = take;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      head_accel[i]   = $signed(head.accel[i]);
      prod_g[i]       = alpha * gravity[i];
      prod_a[i]       = beta * head_accel[i];
      sum[i]          = prod_g[i] + (SUM_W'(prod_a[i]) <<< FILTER_FRACTION_BITS)
                        + SUM_W'(ROUND_HALF);
      gravity_next[i] = sum[i][16 +: GRAV_W];
      grav_rnd[i]     = {gravity[i][GRAV_W-1], gravity[i]}
                        + (GRAV_W + 1)'(1 << (FILTER_FRACTION_BITS - 1));
      body_w[i]       = 16'(total[i]) - 16'($signed(grav_rnd[i][FILTER_FRACTION_BITS +: 15]));
      body[i]         = body_w[i][14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        gravity[i] <= '0;
      end
    end else if (take) begin
      out_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        gravity[i] <= gravity_next[i];
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        total[i] <= head_accel[i];
        omega[i] <= $signed(head.omega[i]);
      end
    end
  end

  a_grav_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> ($stable(gravity[0]) && $stable(gravity[1]) && $stable(gravity[2])))
    else $error("gravity moved without a transfer from the queue");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid) else $error("result lost after transfer from the queue");

  a_pop_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop) else $error("pop while output stalled");

endmodule

// ===== rtl/imu_gravity_split_filter.sv =====
// ----------------------------------------------------------------------------
// imu_gravity_split_filter
// Six-axis frame classifier, gravity low-pass split and rate scaling.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------------
//   input    | in_valid / in_ready     | read_ok, accel_*_sample, rate_*_raw
//   output   | out_valid / out_ready   | body_*, total_*, omega_*
//   config   | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// One frame per cycle sustained while out_ready stays high; a frame is written
// into the queue, then taken into the output register that raises out_valid.
// The gravity register feeds back through the per-axis multipliers.
// Synchronous reset clears held values, gravity, queue and output valid.
// A stalled output fills the two-entry queue, then drops in_ready.
// ----------------------------------------------------------------------------
module imu_gravity_split_filter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [igsf_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             read_ok,
  input  logic signed [15:0]               accel_x_sample,
  input  logic signed [15:0]               accel_y_sample,
  input  logic signed [15:0]               accel_z_sample,
  input  logic signed [15:0]               rate_x_raw,
  input  logic signed [15:0]               rate_y_raw,
  input  logic signed [15:0]               rate_z_raw,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [14:0]               body_x,
  output logic signed [14:0]               body_y,
  output logic signed [14:0]               body_z,
  output logic signed [13:0]               total_x,
  output logic signed [13:0]               total_y,
  output logic signed [13:0]               total_z,
  output logic signed [15:0]               omega_x,
  output logic signed [15:0]               omega_y,
  output logic signed [15:0]               omega_z
);
  import igsf_pkg::*;

  cfg_t               cfg;
  reg_index_t         reg_sel;
  logic               cfg_write;
  logic               push;
  logic               pop;
  logic               queue_full;
  logic               queue_empty;
  frame_t             frame_in;
  frame_t             frame_head;
  logic signed [14:0] body  [3];
  logic signed [13:0] total [3];
  logic signed [15:0] omega [3];

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_factor <= 16'd58982;
      cfg.accel_limit      <= 15'd6144;
      cfg.rate_gain        <= 16'd35744;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SMOOTHING: cfg.smoothing_factor <= pwdata[15:0];
        REG_LIMIT:     cfg.accel_limit      <= pwdata[14:0];
        REG_GAIN:      cfg.rate_gain        <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SMOOTHING: prdata = {16'd0, cfg.smoothing_factor};
      REG_LIMIT:     prdata = {17'd0, cfg.accel_limit};
      REG_GAIN:      prdata = {16'd0, cfg.rate_gain};
      default:       prdata = '0;
    endcase
  end

  igsf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .read_ok        (read_ok),
    .accel_x_sample (accel_x_sample),
    .accel_y_sample (accel_y_sample),
    .accel_z_sample (accel_z_sample),
    .rate_x_raw     (rate_x_raw),
    .rate_y_raw     (rate_y_raw),
    .rate_z_raw     (rate_z_raw),
    .queue_full     (queue_full),
    .push           (push),
    .frame          (frame_in)
  );

  igsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .frame_in  (frame_in),
    .pop       (pop),
    .frame_out (frame_head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  igsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (frame_head),
    .head_valid (!queue_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .body       (body),
    .total      (total),
    .omega      (omega)
  );

  assign body_x  = body[0];
  assign body_y  = body[1];
  assign body_z  = body[2];
  assign total_x = total[0];
  assign total_y = total[1];
  assign total_z = total[2];
  assign omega_x = omega[0];
  assign omega_y = omega[1];
  assign omega_z = omega[2];

endmodule

// ===== tb/igsf_frame_checker.sv =====
// ----------------------------------------------------------------------------
// igsf_frame_checker
// Watches the register port and both frame channels of the gravity split
// filter, keeps its own copy of the settings, held values and gravity
// estimates, predicts every result frame and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module igsf_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [igsf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           read_ok,
  input  logic signed [15:0]             accel_x_sample,
  input  logic signed [15:0]             accel_y_sample,
  input  logic signed [15:0]             accel_z_sample,
  input  logic signed [15:0]             rate_x_raw,
  input  logic signed [15:0]             rate_y_raw,
  input  logic signed [15:0]             rate_z_raw,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [14:0]             body_x,
  input  logic signed [14:0]             body_y,
  input  logic signed [14:0]             body_z,
  input  logic signed [13:0]             total_x,
  input  logic signed [13:0]             total_y,
  input  logic signed [13:0]             total_z,
  input  logic signed [15:0]             omega_x,
  input  logic signed [15:0]             omega_y,
  input  logic signed [15:0]             omega_z,
  output int unsigned                    frames_pending,
  output int unsigned                    mismatch_count
);
  import igsf_pkg::*;

  localparam logic [15:0] SMOOTHING_RESET = 16'd58982;
  localparam logic [14:0] LIMIT_RESET     = 15'd6144;
  localparam logic [15:0] GAIN_RESET      = 16'd35744;

  typedef struct packed {
    logic [2:0][14:0] body;
    logic [2:0][13:0] total;
    logic [2:0][15:0] omega;
  } frame_result_t;

  cfg_t          settings;
  int            held_accel[3];
  int            held_rate[3];
  longint        gravity[3];
  frame_result_t expected_frames[$];
  int unsigned   mismatches;

  function automatic frame_result_t filter_frame(logic ok, logic [2:0][15:0] accel_raw,
                                                 logic [2:0][15:0] rate_raw);
    frame_result_t res;
    longint        alpha;
    longint        beta;
    longint        accel;
    longint        weighted;
    longint        gravity_counts;
    int            sample;
    int            limit;
    int            i;
    alpha = longint'(settings.smoothing_factor);
    beta  = 65536 - alpha;
    limit = int'(settings.accel_limit);
    for (i = 0; i < 3; i++) begin
      if (ok) begin
        sample = int'($signed(accel_raw[i]));
        if (sample <= limit && sample >= -limit) begin
          if (sample > ACCEL_SAT) begin
            sample = ACCEL_SAT;
          end else if (sample < -ACCEL_SAT) begin
            sample = -ACCEL_SAT;
          end
          held_accel[i] = sample;
        end
        held_rate[i] = int'((longint'($signed(rate_raw[i])) * longint'(settings.rate_gain)
                             + ROUND_HALF) >>> 16);
      end
      accel          = longint'(held_accel[i]);
      weighted       = alpha * gravity[i] + beta * (accel <<< FILTER_FRACTION_BITS)
                       + ROUND_HALF;
      gravity[i]     = weighted >>> 16;
      gravity_counts = (gravity[i] + (longint'(1) <<< (FILTER_FRACTION_BITS - 1)))
                       >>> FILTER_FRACTION_BITS;
      res.body[i]    = 15'(accel - gravity_counts);
      res.total[i]   = 14'(accel);
      res.omega[i]   = 16'(held_rate[i]);
    end
    return res;
  endfunction

  task automatic report_field(string field, int axis, int expected_value, int actual_value);
    if (expected_value != actual_value) begin
      mismatches++;
      $display("%0t: %s[%0d] mismatch, expected %0d, actual %0d",
               $time, field, axis, expected_value, actual_value);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t predicted;
    frame_result_t observed;
    int            i;
    if (rst) begin
      settings.smoothing_factor = SMOOTHING_RESET;
      settings.accel_limit      = LIMIT_RESET;
      settings.rate_gain        = GAIN_RESET;
      for (i = 0; i < 3; i++) begin
        held_accel[i] = 0;
        held_rate[i]  = 0;
        gravity[i]    = 0;
      end
      expected_frames.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[PADDR_W-1:2]))
          REG_SMOOTHING: settings.smoothing_factor = pwdata[15:0];
          REG_LIMIT:     settings.accel_limit      = pwdata[14:0];
          REG_GAIN:      settings.rate_gain        = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no frame pending", $time);
        end else begin
          predicted      = expected_frames.pop_front();
          observed.body  = {body_z, body_y, body_x};
          observed.total = {total_z, total_y, total_x};
          observed.omega = {omega_z, omega_y, omega_x};
          for (i = 0; i < 3; i++) begin
            report_field("body", i, int'($signed(predicted.body[i])),
                         int'($signed(observed.body[i])));
            report_field("total", i, int'($signed(predicted.total[i])),
                         int'($signed(observed.total[i])));
            report_field("omega", i, int'($signed(predicted.omega[i])),
                         int'($signed(observed.omega[i])));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_frames.push_back(filter_frame(read_ok,
                                               {accel_z_sample, accel_y_sample,
                                                accel_x_sample},
                                               {rate_z_raw, rate_y_raw, rate_x_raw}));
      end
    end
    frames_pending <= expected_frames.size();
    mismatch_count <= mismatches;
  end

endmodule

// ===== tb/tb_imu_gravity_split_filter.sv =====
// ----------------------------------------------------------------------------
// tb_imu_gravity_split_filter
// Drives sensor frames and register writes into the gravity split filter
// under random sender gaps and receiver stalls, through several filter
// settings including the extremes. The frame checker predicts and compares;
// this module issues the verdict and guards against a hung handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_imu_gravity_split_filter;
  import igsf_pkg::*;

  localparam int         WATCHDOG_LIMIT   = 2000;
  localparam int         PHASE_COUNT      = 6;
  localparam int         FRAMES_PER_PHASE = 240;
  localparam int         SETTLE_CYCLES    = 8;
  localparam logic [1:0] REG_UNUSED       = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic                 read_ok;
  logic signed [15:0]   accel_x_sample;
  logic signed [15:0]   accel_y_sample;
  logic signed [15:0]   accel_z_sample;
  logic signed [15:0]   rate_x_raw;
  logic signed [15:0]   rate_y_raw;
  logic signed [15:0]   rate_z_raw;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [14:0]   body_x;
  logic signed [14:0]   body_y;
  logic signed [14:0]   body_z;
  logic signed [13:0]   total_x;
  logic signed [13:0]   total_y;
  logic signed [13:0]   total_z;
  logic signed [15:0]   omega_x;
  logic signed [15:0]   omega_y;
  logic signed [15:0]   omega_z;
  int unsigned          frames_pending;
  int unsigned          mismatch_count;
  logic                 burst;
  int                   accel_limit_now;
  int                   idle_cycles;

  always #1 clk = ~clk;

  imu_gravity_split_filter DUT (.*);

  igsf_frame_checker frame_checker (.*);

  task automatic send_frame(logic ok, int ax, int ay, int az, int rx, int ry, int rz);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    read_ok        = ok;
    accel_x_sample = 16'(ax);
    accel_y_sample = 16'(ay);
    accel_z_sample = 16'(az);
    rate_x_raw     = 16'(rx);
    rate_y_raw     = 16'(ry);
    rate_z_raw     = 16'(rz);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_frames();
    in_valid = 1'b0;
    while (frames_pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(logic [1:0] index, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {index, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_filter_settings(int unsigned alpha, int unsigned limit,
                                      int unsigned gain);
    drain_frames();
    apb_write(REG_SMOOTHING, {16'($urandom), 16'(alpha)});
    apb_write(REG_LIMIT, {17'($urandom), 15'(limit)});
    apb_write(REG_GAIN, {16'($urandom), 16'(gain)});
    accel_limit_now = int'(limit);
  endtask

  function automatic int pick_accel(int limit);
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($signed(16'($urandom)));
      3: begin
        case ($urandom_range(0, 3))
          0: return limit;
          1: return -limit;
          2: return limit + 1;
          default: return -limit - 1;
        endcase
      end
      default: return int'($urandom_range(0, 2 * limit)) - limit;
    endcase
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return int'($urandom_range(0, 2)) - 1;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = burst ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int phase;
    int n;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    read_ok         = 1'b0;
    accel_x_sample  = '0;
    accel_y_sample  = '0;
    accel_z_sample  = '0;
    rate_x_raw      = '0;
    rate_y_raw      = '0;
    rate_z_raw      = '0;
    burst           = 1'b0;
    accel_limit_now = 6144;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_frame(1'b1, 0, 0, 0, 0, 0, 0);
    send_frame(1'b1, 6144, -6144, 0, 32767, -32768, 0);
    send_frame(1'b1, 6145, -6145, 32767, 1, -1, 0);
    send_frame(1'b1, -32768, 100, -100, -1, 1, 16384);
    send_frame(1'b0, 1234, -4321, 32767, -32768, 32767, 555);
    send_frame(1'b0, -32768, 0, 6000, 1, 2, 3);
    send_frame(1'b1, 2048, -2048, 2048, -20000, 20000, -1);
    send_frame(1'b1, 6144, 6144, 6144, 0, 0, 0);

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: ;
        1: begin
          load_filter_settings(0, 32767, 65535);
          send_frame(1'b1, 32767, -32768, 6145, 32767, -32768, 0);
          send_frame(1'b1, -6145, 12000, -12000, -1, 1, 0);
          send_frame(1'b0, 0, 0, 0, 0, 0, 0);
        end
        2: begin
          load_filter_settings(65535, 0, 0);
          send_frame(1'b1, 0, 1, -1, 32767, -32768, 5);
          send_frame(1'b1, -32768, 32767, 0, 1, -1, 0);
        end
        3: begin
          load_filter_settings(58982, 6144, 35744);
          apb_write(REG_UNUSED, $urandom);
        end
        default: begin
          load_filter_settings($urandom_range(0, 65535), $urandom_range(0, 9000),
                               $urandom_range(0, 65535));
        end
      endcase
      for (n = 0; n < FRAMES_PER_PHASE; n++) begin
        burst = (n >= 100 && n < 140);
        if ($urandom_range(0, 99) == 0) begin
          drain_frames();
        end
        send_frame($urandom_range(0, 9) != 0,
                   pick_accel(accel_limit_now), pick_accel(accel_limit_now),
                   pick_accel(accel_limit_now), pick_rate(), pick_rate(), pick_rate());
      end
    end

    burst = 1'b0;
    drain_frames();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
